// ----- rtl/core/csc_pkg.sv -----
package csc_pkg;

   // event codes carried on the request channel
   typedef enum logic [3:0] {
      OP_READ_BYTE   = 4'd0,
      OP_WRITE_BYTE  = 4'd1,
      OP_READ_WORD   = 4'd2,
      OP_WRITE_WORD  = 4'd3,
      OP_CARD        = 4'd4,
      OP_REQ_WIRE    = 4'd5,
      OP_PROM_SEL_HI = 4'd6,
      OP_PROM_SEL_LO = 4'd7,
      OP_PROM_CLK_HI = 4'd8,
      OP_PROM_LOAD   = 4'd9
   } op_type;

   // register offsets
   localparam logic [3:0] REG_INT_STATUS = 4'd6;
   localparam logic [3:0] REG_INT_MASK   = 4'd7;
   localparam logic [3:0] REG_INT_CLEAR  = 4'd8;
   localparam logic [3:0] REG_SOCK_STA_A = 4'd9;
   localparam logic [3:0] REG_SOCK_STA_B = 4'd10;
   localparam logic [3:0] REG_SOCK_CTRL  = 4'd11;
   localparam logic [3:0] REG_WAKE_FIRST = 4'd12;
   localparam logic [3:0] REG_SCRATCH_LO = 4'd13;
   localparam logic [3:0] REG_SCRATCH_HI = 4'd14;
   localparam logic [3:0] REG_WAKE_SEC   = 4'd15;

   localparam logic [7:0] STA_A_CARD  = 8'hB8;
   localparam logic [7:0] STA_A_EMPTY = 8'h01;
   localparam logic [7:0] STA_B_CARD  = 8'h03;
   localparam logic [7:0] STA_B_EMPTY = 8'h00;
   localparam logic [7:0] UNMAPPED    = 8'hFF;
   localparam logic [7:0] INT_CARD_REQ = 8'h01;

   localparam logic [7:0] CSUM_SEED = 8'd66;
   // seed folded with the power-up contents (20 ^ 20 ^ 20 ^ 30)
   localparam logic [7:0] CSUM_RESET = CSUM_SEED ^ 8'd20 ^ 8'd30;

   localparam int PROM_BYTES_DEF      = 128;
   localparam int FRAME_BITS_DEF      = 9;
   localparam int WORD_INDEX_MASK_DEF = 63;

   typedef struct packed {
      logic       sel_high;
      logic       clock;
      logic       load;
      logic       start_bit;
      logic [6:0] index;
      logic [7:0] data;
   } prom_cmd_type;

   typedef struct packed {
      logic shift_out;
      logic dout;
   } prom_rsp_type;

   function automatic logic [7:0] prom_reset_byte(input logic [7:0] idx);
      logic [7:0] val;
      val = 8'd0;
      if (idx >= 8'd10 && idx <= 8'd12) val = 8'd20;
      if (idx == 8'd13) val = 8'd30;
      return val;
   endfunction

endpackage

// ----- rtl/core/csc_ram.sv -----
module csc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic                     rd_en_b,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en_a) rd_a_ff <= mem_ff[rd_addr_a];
      if (rd_en_b) rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- rtl/core/csc_prom.sv -----
module csc_prom import csc_pkg::*; #(
   parameter int PROM_BYTES      = PROM_BYTES_DEF,
   parameter int FRAME_BITS      = FRAME_BITS_DEF,
   parameter int WORD_INDEX_MASK = WORD_INDEX_MASK_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  prom_cmd_type cmd,
   output prom_rsp_type rsp
);

   localparam int AW     = $clog2(PROM_BYTES);
   localparam int CW     = $clog2(FRAME_BITS + 1);
   localparam int MW     = $clog2(WORD_INDEX_MASK + 1);
   localparam int VW     = MW + 1;
   localparam int RW     = (VW > AW) ? VW : AW;
   localparam int LAST   = PROM_BYTES - 1;
   localparam int QSTEPS = $clog2((2 * WORD_INDEX_MASK) / PROM_BYTES + 1);

   logic [15:0]   frame_ff, frame_in;
   logic [CW-1:0] bits_ff, bits_in;
   logic [15:0]   word_ff, word_in;
   logic          word_pend_ff, word_pend_in;
   logic [7:0]    csum_ff, csum_in;
   logic          csum_pend_ff, csum_pend_in;
   logic [7:0]    load_byte_ff;
   logic          vld_ff [PROM_BYTES];
   logic          a_vld_ff, b_vld_ff;
   logic [7:0]    a_rst_ff, b_rst_ff;
   logic          lo_csum_ff, lo_csum_in;
   logic          hi_csum_ff, hi_csum_in;
   logic [7:0]    csum_cap_ff;

   logic          wr_en, rd_en_a, rd_en_b;
   logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [7:0]    rd_data_a, rd_data_b;
   logic [7:0]    old_a, old_b, csum_eff;
   logic [15:0]   word_eff;
   logic [15:0]   masked;
   logic [RW-1:0] rem;
   logic [AW-1:0] at, nx;
   logic [8:0]    idx_w;

   csc_ram #(.WIDTH(8), .DEPTH(PROM_BYTES)) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (cmd.data),
      .rd_en_a   (rd_en_a),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_en_b   (rd_en_b),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // read data of the previous transaction, with never-written bytes at power-up value
   assign old_a    = a_vld_ff ? rd_data_a : a_rst_ff;
   assign old_b    = b_vld_ff ? rd_data_b : b_rst_ff;
   assign csum_eff = csum_pend_ff ? (csum_ff ^ old_a ^ load_byte_ff) : csum_ff;
   assign word_eff = word_pend_ff ?
                     {hi_csum_ff ? csum_cap_ff : old_b, lo_csum_ff ? csum_cap_ff : old_a} :
                     word_ff;

   assign idx_w = 9'(cmd.index);

   always_comb begin
      frame_in     = frame_ff;
      bits_in      = bits_ff;
      word_in      = word_eff;
      word_pend_in = 1'b0;
      csum_in      = csum_eff;
      csum_pend_in = 1'b0;
      lo_csum_in   = 1'b0;
      hi_csum_in   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_w[AW-1:0];
      rd_en_a      = 1'b0;
      rd_en_b      = 1'b0;
      rd_addr_a    = idx_w[AW-1:0];
      rd_addr_b    = '0;
      rsp          = '0;
      masked       = '0;
      rem          = '0;
      at           = '0;
      nx           = '0;

      if (cmd.sel_high) begin
         frame_in = '0;
         bits_in  = '0;
         word_in  = '0;
      end else if (cmd.clock) begin
         if (bits_ff < CW'(FRAME_BITS)) begin
            if (!(bits_ff == '0 && !cmd.start_bit)) begin
               frame_in = {frame_ff[14:0], cmd.start_bit};
               bits_in  = bits_ff + CW'(1);
               if (bits_in == CW'(FRAME_BITS)) begin
                  masked = frame_in & 16'(WORD_INDEX_MASK);
                  rem    = RW'({masked[MW-1:0], 1'b0});
                  // remainder by the PROM size, one restoring step per quotient bit
                  for (int i = QSTEPS - 1; i >= 0; i--) begin
                     if (rem >= RW'(PROM_BYTES << i)) rem = rem - RW'(PROM_BYTES << i);
                  end
                  at           = rem[AW-1:0];
                  nx           = (at == AW'(LAST)) ? '0 : at + AW'(1);
                  rd_en_a      = fire;
                  rd_en_b      = fire;
                  rd_addr_a    = at;
                  rd_addr_b    = nx;
                  lo_csum_in   = (at == AW'(LAST));
                  hi_csum_in   = (nx == AW'(LAST));
                  word_pend_in = 1'b1;
               end
            end
         end else begin
            rsp.shift_out = 1'b1;
            rsp.dout      = word_eff[15];
            word_in       = {word_eff[14:0], 1'b0};
         end
      end else if (cmd.load) begin
         if (idx_w < 9'(LAST)) begin
            // write the new byte and fetch the old one for the checksum update
            wr_en        = fire;
            rd_en_a      = fire;
            csum_pend_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff     <= '0;
         bits_ff      <= '0;
         word_ff      <= '0;
         word_pend_ff <= 1'b0;
         csum_ff      <= CSUM_RESET;
         csum_pend_ff <= 1'b0;
         for (int i = 0; i < PROM_BYTES; i++) vld_ff[i] <= 1'b0;
      end else if (fire) begin
         frame_ff     <= frame_in;
         bits_ff      <= bits_in;
         word_ff      <= word_in;
         word_pend_ff <= word_pend_in;
         csum_ff      <= csum_in;
         csum_pend_ff <= csum_pend_in;
         if (wr_en) vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         load_byte_ff <= cmd.data;
         lo_csum_ff   <= lo_csum_in;
         hi_csum_ff   <= hi_csum_in;
         csum_cap_ff  <= csum_eff;
      end
      if (rd_en_a) begin
         a_vld_ff <= vld_ff[rd_addr_a];
         a_rst_ff <= prom_reset_byte(8'(rd_addr_a));
      end
      if (rd_en_b) begin
         b_vld_ff <= vld_ff[rd_addr_b];
         b_rst_ff <= prom_reset_byte(8'(rd_addr_b));
      end
   end

endmodule

// ----- rtl/core/card_socket_controller_regs_top.sv -----
// Card socket register block with serial PROM.
// A transaction accepted from the request port passes through the input register, then the
// response register, which drives the response port.
// Throughput: one transaction per cycle unless rsp_ready stalls; the PROM word fetch and
// checksum update read the PROM RAM and use the data with the following transaction.
// Reset (synchronous): map registers cleared, no card, PROM back to power-up contents.
module card_socket_controller_regs_top import csc_pkg::*; #(
   parameter int PROM_BYTES      = PROM_BYTES_DEF,
   parameter int FRAME_BITS      = FRAME_BITS_DEF,
   parameter int WORD_INDEX_MASK = WORD_INDEX_MASK_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_operation,
   input  logic [3:0]  req_register_address,
   input  logic [31:0] req_data,
   input  logic [6:0]  req_prom_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_prom_data_bit
);

   logic        in_vld_ff;
   logic [3:0]  in_op_ff;
   logic [3:0]  in_addr_ff;
   logic [31:0] in_data_ff;
   logic [6:0]  in_pidx_ff;

   logic        rsp_vld_ff;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic        rsp_bit_ff;

   logic [7:0] int_status_ff, int_status_in;
   logic [7:0] int_mask_ff, int_mask_in;
   logic [7:0] sock_ctrl_ff, sock_ctrl_in;
   logic [7:0] wake_first_ff, wake_first_in;
   logic [7:0] wake_sec_ff, wake_sec_in;
   logic [7:0] scratch_lo_ff, scratch_lo_in;
   logic [7:0] scratch_hi_ff, scratch_hi_in;
   logic       card_ff, card_in;
   logic       wire_last_ff, wire_last_in;

   logic         fire;
   op_type       op;
   logic [7:0]   rd_map [16];
   logic         wr_en [16];
   logic [7:0]   wr_byte [16];
   logic [4:0]   addr_k;
   prom_cmd_type prom_cmd;
   prom_rsp_type prom_rsp;

   assign fire      = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || fire;
   assign op        = op_type'(in_op_ff);

   always_comb begin
      for (int i = 0; i < 16; i++) rd_map[i] = UNMAPPED;
      rd_map[REG_INT_STATUS] = int_status_ff;
      rd_map[REG_INT_MASK]   = int_mask_ff;
      rd_map[REG_INT_CLEAR]  = 8'h00;
      rd_map[REG_SOCK_STA_A] = card_ff ? STA_A_CARD : STA_A_EMPTY;
      rd_map[REG_SOCK_STA_B] = card_ff ? STA_B_CARD : STA_B_EMPTY;
      rd_map[REG_SOCK_CTRL]  = sock_ctrl_ff;
      rd_map[REG_WAKE_FIRST] = wake_first_ff;
      rd_map[REG_SCRATCH_LO] = scratch_lo_ff;
      rd_map[REG_SCRATCH_HI] = scratch_hi_ff;
      rd_map[REG_WAKE_SEC]   = wake_sec_ff;
   end

   // byte lanes of a word access land on consecutive offsets; past offset 15 is unmapped
   always_comb begin
      rsp_data_in = '0;
      addr_k      = '0;
      for (int i = 0; i < 16; i++) begin
         wr_en[i]   = 1'b0;
         wr_byte[i] = 8'h00;
      end
      for (int k = 0; k < 4; k++) begin
         addr_k = 5'(in_addr_ff) + 5'(k);
         if (op == OP_READ_WORD || (op == OP_READ_BYTE && k == 0)) begin
            rsp_data_in[8*k +: 8] = addr_k[4] ? UNMAPPED : rd_map[addr_k[3:0]];
         end
         if ((op == OP_WRITE_WORD || (op == OP_WRITE_BYTE && k == 0)) && !addr_k[4]) begin
            wr_en[addr_k[3:0]]   = 1'b1;
            wr_byte[addr_k[3:0]] = in_data_ff[8*k +: 8];
         end
      end
   end

   always_comb begin
      prom_cmd           = '0;
      prom_cmd.start_bit = wake_first_ff[2];
      prom_cmd.index     = in_pidx_ff;
      prom_cmd.data      = in_data_ff[7:0];
      unique case (op)
         OP_PROM_SEL_HI: prom_cmd.sel_high = 1'b1;
         OP_PROM_CLK_HI: prom_cmd.clock    = 1'b1;
         OP_PROM_LOAD:   prom_cmd.load     = 1'b1;
         default:        prom_cmd.clock    = 1'b0;
      endcase
   end

   csc_prom #(
      .PROM_BYTES      (PROM_BYTES),
      .FRAME_BITS      (FRAME_BITS),
      .WORD_INDEX_MASK (WORD_INDEX_MASK)
   ) u_prom (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .cmd   (prom_cmd),
      .rsp   (prom_rsp)
   );

   always_comb begin
      int_status_in = int_status_ff;
      if (wr_en[REG_INT_STATUS]) int_status_in = int_status_in & ~wr_byte[REG_INT_STATUS];
      if (wr_en[REG_INT_CLEAR])  int_status_in = int_status_in & ~wr_byte[REG_INT_CLEAR];
      int_mask_in   = wr_en[REG_INT_MASK]   ? wr_byte[REG_INT_MASK]   : int_mask_ff;
      sock_ctrl_in  = wr_en[REG_SOCK_CTRL]  ? wr_byte[REG_SOCK_CTRL]  : sock_ctrl_ff;
      wake_first_in = wr_en[REG_WAKE_FIRST] ? wr_byte[REG_WAKE_FIRST] : wake_first_ff;
      scratch_lo_in = wr_en[REG_SCRATCH_LO] ? wr_byte[REG_SCRATCH_LO] : scratch_lo_ff;
      scratch_hi_in = wr_en[REG_SCRATCH_HI] ? wr_byte[REG_SCRATCH_HI] : scratch_hi_ff;
      wake_sec_in   = wr_en[REG_WAKE_SEC]   ? wr_byte[REG_WAKE_SEC]   : wake_sec_ff;
      card_in       = card_ff;
      wire_last_in  = wire_last_ff;
      if (op == OP_CARD) card_in = in_data_ff[0];
      if (op == OP_REQ_WIRE) begin
         wire_last_in = in_data_ff[0];
         if (in_data_ff[0] && !wire_last_ff) int_status_in = int_status_in | INT_CARD_REQ;
      end
      if (prom_rsp.shift_out) wake_first_in[3] = prom_rsp.dout;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         int_status_ff <= '0;
         int_mask_ff   <= '0;
         sock_ctrl_ff  <= '0;
         wake_first_ff <= '0;
         wake_sec_ff   <= '0;
         scratch_lo_ff <= '0;
         scratch_hi_ff <= '0;
         card_ff       <= 1'b0;
         wire_last_ff  <= 1'b0;
      end else begin
         if (req_ready) in_vld_ff <= req_valid;
         if (fire) begin
            rsp_vld_ff    <= 1'b1;
            int_status_ff <= int_status_in;
            int_mask_ff   <= int_mask_in;
            sock_ctrl_ff  <= sock_ctrl_in;
            wake_first_ff <= wake_first_in;
            wake_sec_ff   <= wake_sec_in;
            scratch_lo_ff <= scratch_lo_in;
            scratch_hi_ff <= scratch_hi_in;
            card_ff       <= card_in;
            wire_last_ff  <= wire_last_in;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_op_ff   <= req_operation;
         in_addr_ff <= req_register_address;
         in_data_ff <= req_data;
         in_pidx_ff <= req_prom_index;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_bit_ff  <= wake_first_in[3];
      end
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_prom_data_bit = rsp_bit_ff;

endmodule

// ----- tb/card_socket_controller_regs_top_tb.sv -----
`timescale 1ns / 100ps

module card_socket_controller_regs_top_tb;
   import csc_pkg::*;

   localparam int         ITEM_TARGET     = 1050;
   localparam int         CALM_AFTER      = 900;
   localparam int         QUIET_LIMIT     = 2000;
   localparam int         HOLD_CYCLES     = 400;
   localparam int         DRAIN_CYCLES    = 10;
   localparam int         LAST_REG        = REG_WAKE_SEC;
   localparam logic [3:0] REG_UNMAPPED_LO = 4'd0;
   localparam int         OP_UNUSED_LO    = 10;
   localparam int         OP_UNUSED_HI    = 15;
   localparam int         WAKE_PROM_DI    = 2;
   localparam int         WAKE_PROM_DO    = 3;

   class socket_register_scoreboard;
      typedef struct {
         logic [31:0] read_data;
         logic        prom_bit;
      } socket_response;

      socket_response due_rsp[$];
      int             mismatches;

      logic [7:0]  int_status, int_mask, sock_ctrl, wake_first, wake_second;
      logic [7:0]  scratch_lo, scratch_hi;
      logic        card_present, wire_last;
      logic [7:0]  prom_image [PROM_BYTES_DEF];
      logic [15:0] frame_bits, word_bits;
      int          frame_count;

      function new();
         mismatches   = 0;
         int_status   = '0;
         int_mask     = '0;
         sock_ctrl    = '0;
         wake_first   = '0;
         wake_second  = '0;
         scratch_lo   = '0;
         scratch_hi   = '0;
         card_present = 1'b0;
         wire_last    = 1'b0;
         frame_bits   = '0;
         word_bits    = '0;
         frame_count  = 0;
         foreach (prom_image[i]) prom_image[i] = '0;
         prom_image[10] = 8'd20;
         prom_image[11] = 8'd20;
         prom_image[12] = 8'd20;
         prom_image[13] = 8'd30;
         refresh_checksum();
      endfunction

      // last PROM byte holds the XOR of all others folded with the seed
      function void refresh_checksum();
         logic [7:0] acc;
         acc = CSUM_SEED;
         for (int i = 0; i < PROM_BYTES_DEF - 1; i++) acc ^= prom_image[i];
         prom_image[PROM_BYTES_DEF - 1] = acc;
      endfunction

      function logic [7:0] reg_read(logic [3:0] addr);
         case (addr)
            REG_INT_STATUS: return int_status;
            REG_INT_MASK:   return int_mask;
            REG_INT_CLEAR:  return 8'h00;
            REG_SOCK_STA_A: return card_present ? STA_A_CARD : STA_A_EMPTY;
            REG_SOCK_STA_B: return card_present ? STA_B_CARD : STA_B_EMPTY;
            REG_SOCK_CTRL:  return sock_ctrl;
            REG_WAKE_FIRST: return wake_first;
            REG_SCRATCH_LO: return scratch_lo;
            REG_SCRATCH_HI: return scratch_hi;
            REG_WAKE_SEC:   return wake_second;
            default:        return UNMAPPED;
         endcase
      endfunction

      function void reg_write(logic [3:0] addr, logic [7:0] val);
         case (addr)
            REG_INT_STATUS: int_status &= ~val;
            REG_INT_CLEAR:  int_status &= ~val;
            REG_INT_MASK:   int_mask = val;
            REG_SOCK_CTRL:  sock_ctrl = val;
            REG_WAKE_FIRST: wake_first = val;
            REG_SCRATCH_LO: scratch_lo = val;
            REG_SCRATCH_HI: scratch_hi = val;
            REG_WAKE_SEC:   wake_second = val;
            default: ;
         endcase
      endfunction

      // frame phase: start bit then address bits; afterwards shift the word out MSB first
      function void prom_clock_edge();
         logic din;
         int   at;
         if (frame_count < FRAME_BITS_DEF) begin
            din = wake_first[WAKE_PROM_DI];
            if (frame_count == 0 && !din) return;
            frame_bits = {frame_bits[14:0], din};
            frame_count++;
            if (frame_count == FRAME_BITS_DEF) begin
               at = ((int'(frame_bits) & WORD_INDEX_MASK_DEF) * 2) % PROM_BYTES_DEF;
               word_bits = {prom_image[(at + 1) % PROM_BYTES_DEF], prom_image[at]};
            end
         end else begin
            wake_first[WAKE_PROM_DO] = word_bits[15];
            word_bits = word_bits << 1;
         end
      endfunction

      function void note_event(logic [3:0] op_code, logic [3:0] addr, logic [31:0] data,
                               logic [6:0] idx);
         socket_response r;
         int             ofs;
         r.read_data = '0;
         case (op_code)
            OP_READ_BYTE: r.read_data = {24'h0, reg_read(addr)};
            OP_WRITE_BYTE: reg_write(addr, data[7:0]);
            OP_READ_WORD: begin
               for (int k = 0; k < 4; k++) begin
                  ofs = int'(addr) + k;
                  r.read_data[8*k +: 8] = (ofs <= LAST_REG) ? reg_read(ofs[3:0]) : UNMAPPED;
               end
            end
            OP_WRITE_WORD: begin
               for (int k = 0; k < 4; k++) begin
                  ofs = int'(addr) + k;
                  if (ofs <= LAST_REG) reg_write(ofs[3:0], data[8*k +: 8]);
               end
            end
            OP_CARD: card_present = data[0];
            OP_REQ_WIRE: begin
               if (data[0] && !wire_last) int_status |= INT_CARD_REQ;
               wire_last = data[0];
            end
            OP_PROM_SEL_HI: begin
               frame_bits  = '0;
               word_bits   = '0;
               frame_count = 0;
            end
            OP_PROM_CLK_HI: prom_clock_edge();
            OP_PROM_LOAD: begin
               if (int'(idx) < PROM_BYTES_DEF - 1) begin
                  prom_image[idx] = data[7:0];
                  refresh_checksum();
               end
            end
            default: ;
         endcase
         r.prom_bit = wake_first[WAKE_PROM_DO];
         due_rsp.push_back(r);
      endfunction

      function void check_response(logic [31:0] rd, logic dout);
         socket_response r;
         if (due_rsp.size() == 0) begin
            $display("%0t: unexpected response, expected none, got read_data=%h prom_data_bit=%b",
                     $time, rd, dout);
            mismatches++;
            return;
         end
         r = due_rsp.pop_front();
         if (rd !== r.read_data) begin
            $display("%0t: read_data mismatch, expected %h, got %h", $time, r.read_data, rd);
            mismatches++;
         end
         if (dout !== r.prom_bit) begin
            $display("%0t: prom_data_bit mismatch, expected %b, got %b", $time, r.prom_bit, dout);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [3:0]  req_operation;
   logic [3:0]  req_register_address;
   logic [31:0] req_data;
   logic [6:0]  req_prom_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_data;
   logic        rsp_prom_data_bit;

   socket_register_scoreboard sb = new();

   int events_sent = 0;
   bit tx_idle_on  = 1'b1;
   bit rx_idle_on  = 1'b1;
   bit rx_hold_req = 1'b0;

   card_socket_controller_regs_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_register_address (req_register_address),
      .req_data             (req_data),
      .req_prom_index       (req_prom_index),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_read_data        (rsp_read_data),
      .rsp_prom_data_bit    (rsp_prom_data_bit)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_event(req_operation, req_register_address, req_data, req_prom_index);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_read_data, rsp_prom_data_bit);
      end
   end

   // response side: random stalls, plus one long hold-off so the block backs up
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_req) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rx_hold_req = 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after the transaction
   task automatic send_event(input logic [3:0] op_code, input logic [3:0] addr,
                             input logic [31:0] data, input logic [6:0] idx);
      if (tx_idle_on && $urandom_range(0, 9) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid            = 1'b1;
      req_operation        = op_code;
      req_register_address = addr;
      req_data             = data;
      req_prom_index       = idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      events_sent++;
   endtask

   task automatic random_event();
      logic [3:0] op_code;
      logic [6:0] idx;
      if ($urandom_range(0, 19) == 0) op_code = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else op_code = 4'($urandom_range(int'(OP_READ_BYTE), int'(OP_PROM_LOAD)));
      idx = ($urandom_range(0, 15) == 0) ? 7'(PROM_BYTES_DEF - 1)
                                         : 7'($urandom_range(0, PROM_BYTES_DEF - 2));
      send_event(op_code, 4'($urandom), $urandom, idx);
   endtask

   task automatic write_wake(input logic din);
      logic [31:0] d;
      d = $urandom;
      d[WAKE_PROM_DI] = din;
      send_event(OP_WRITE_BYTE, REG_WAKE_FIRST, d, 7'($urandom));
   endtask

   // select, start bit, eight frame bits, then clock the word out with a few peeks
   task automatic prom_word_read();
      logic [7:0] frame;
      frame = 8'($urandom);
      send_event(OP_PROM_SEL_HI, 4'($urandom), $urandom, 7'($urandom));
      if ($urandom_range(0, 3) == 0) begin
         write_wake(1'b0);
         send_event(OP_PROM_CLK_HI, 4'($urandom), $urandom, 7'($urandom));
      end
      write_wake(1'b1);
      send_event(OP_PROM_CLK_HI, 4'($urandom), $urandom, 7'($urandom));
      for (int i = 7; i >= 0; i--) begin
         if ($urandom_range(0, 24) == 0) random_event();
         write_wake(frame[i]);
         send_event(OP_PROM_CLK_HI, 4'($urandom), $urandom, 7'($urandom));
      end
      repeat ($urandom_range(12, 20)) begin
         if ($urandom_range(0, 3) == 0)
            send_event(OP_READ_BYTE, REG_WAKE_FIRST, $urandom, 7'($urandom));
         if ($urandom_range(0, 39) == 0) random_event();
         send_event(OP_PROM_CLK_HI, 4'($urandom), $urandom, 7'($urandom));
      end
   endtask

   task automatic interrupt_round();
      if ($urandom_range(0, 2) == 0)
         send_event(OP_WRITE_BYTE, REG_INT_MASK, $urandom, 7'($urandom));
      send_event(OP_REQ_WIRE, 4'($urandom), $urandom, 7'($urandom));
      send_event(OP_REQ_WIRE, 4'($urandom), $urandom, 7'($urandom));
      send_event(($urandom_range(0, 1) == 1) ? OP_READ_BYTE : OP_READ_WORD,
                 REG_INT_STATUS, $urandom, 7'($urandom));
      send_event(OP_CARD, 4'($urandom), $urandom, 7'($urandom));
      send_event(OP_WRITE_BYTE, ($urandom_range(0, 1) == 1) ? REG_INT_STATUS : REG_INT_CLEAR,
                 $urandom, 7'($urandom));
      send_event(OP_READ_WORD, 4'($urandom_range(int'(REG_INT_STATUS), LAST_REG)),
                 $urandom, 7'($urandom));
   endtask

   initial begin
      int pick;
      int next_phase;
      bit hold_done;
      next_phase           = 0;
      hold_done            = 1'b0;
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_operation        = OP_READ_BYTE;
      req_register_address = '0;
      req_data             = '0;
      req_prom_index       = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_event(OP_READ_WORD, REG_UNMAPPED_LO, 32'h0, 7'd0);
      send_event(OP_READ_WORD, REG_SCRATCH_LO, 32'hFFFF_FFFF, 7'h7F);  // runs off the top
      send_event(OP_WRITE_WORD, REG_INT_STATUS, 32'hFFFF_FFFF, 7'd0);
      send_event(OP_WRITE_BYTE, REG_SOCK_CTRL, 32'hDEAD_BEA5, 7'd0);
      send_event(OP_WRITE_WORD, REG_WAKE_FIRST, 32'h5A3C_96F0, 7'd3);
      send_event(OP_READ_WORD, REG_SOCK_CTRL, 32'h0, 7'd0);
      send_event(OP_READ_WORD, REG_INT_CLEAR, 32'h0, 7'd0);
      send_event(OP_CARD, REG_UNMAPPED_LO, 32'hFFFF_FFFF, 7'd0);
      send_event(OP_READ_WORD, REG_INT_CLEAR, 32'h0, 7'd0);
      send_event(OP_CARD, REG_WAKE_SEC, 32'hFFFF_FFFE, 7'd0);
      send_event(OP_READ_BYTE, REG_SOCK_STA_A, 32'h0, 7'd0);
      send_event(OP_REQ_WIRE, REG_UNMAPPED_LO, 32'h0000_0001, 7'd0);
      send_event(OP_REQ_WIRE, REG_UNMAPPED_LO, 32'hFFFF_FFFF, 7'd0);  // level held, no edge
      send_event(OP_READ_BYTE, REG_INT_STATUS, 32'h0, 7'd0);
      send_event(OP_WRITE_BYTE, REG_INT_CLEAR, 32'h0000_0001, 7'd0);
      send_event(OP_REQ_WIRE, REG_UNMAPPED_LO, 32'h0, 7'd0);
      send_event(OP_REQ_WIRE, REG_UNMAPPED_LO, 32'h1, 7'd0);
      send_event(OP_WRITE_BYTE, REG_INT_STATUS, 32'h0000_00FF, 7'd0);
      send_event(OP_READ_BYTE, REG_INT_STATUS, 32'h0, 7'd0);
      send_event(OP_PROM_CLK_HI, REG_UNMAPPED_LO, 32'h0, 7'd0);      // no start bit yet
      send_event(OP_PROM_SEL_LO, REG_WAKE_SEC, 32'hFFFF_FFFF, 7'h7F);
      send_event(4'(OP_UNUSED_HI), REG_WAKE_SEC, 32'hFFFF_FFFF, 7'h7F);
      send_event(OP_PROM_LOAD, REG_UNMAPPED_LO, 32'hFFFF_FFFF, 7'(PROM_BYTES_DEF - 1));
      send_event(OP_PROM_LOAD, REG_UNMAPPED_LO, 32'hFFFF_FF5A, 7'd0);
      send_event(OP_PROM_LOAD, REG_UNMAPPED_LO, 32'h0, 7'(PROM_BYTES_DEF - 2));

      while (events_sent < ITEM_TARGET) begin
         if (events_sent >= next_phase) begin
            next_phase = events_sent + 100;
            if (events_sent < CALM_AFTER) begin
               tx_idle_on = ($urandom_range(0, 9) < 7);
               rx_idle_on = ($urandom_range(0, 9) < 7);
            end else begin
               tx_idle_on = 1'b0;
               rx_idle_on = 1'b0;
            end
         end
         if (!hold_done && events_sent >= 300) begin
            rx_hold_req = 1'b1;
            hold_done   = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 40) prom_word_read();
         else if (pick < 55) begin
            repeat ($urandom_range(1, 6))
               send_event(OP_PROM_LOAD, 4'($urandom), $urandom,
                          ($urandom_range(0, 9) == 0) ? 7'(PROM_BYTES_DEF - 1) : 7'($urandom));
         end
         else if (pick < 70) interrupt_round();
         else random_event();
      end
      req_valid = 1'b0;

      while (sb.due_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.due_rsp.size() == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
